### src/tcc_pkg.sv
// Shared types and constants for the terminal cursor controller.
`timescale 1ns / 1ps
package tcc_pkg;

    localparam int MaxColumns = 256;
    localparam int MaxRows    = 64;
    localparam int TabSpacing = 8;
    localparam int ColW       = $clog2(MaxColumns);
    localparam int RowW       = $clog2(MaxRows);

    typedef enum logic [4:0] {
        ACT_WRITE      = 5'd0,
        ACT_MOVE_ABS   = 5'd1,
        ACT_MOVE_REL   = 5'd2,
        ACT_SET_COL    = 5'd3,
        ACT_SET_ROW    = 5'd4,
        ACT_CR         = 5'd5,
        ACT_INDEX      = 5'd6,
        ACT_REV_INDEX  = 5'd7,
        ACT_NEXT_LINE  = 5'd8,
        ACT_TAB_FWD    = 5'd9,
        ACT_TAB_BACK   = 5'd10,
        ACT_SET_STOP   = 5'd11,
        ACT_CLR_STOP   = 5'd12,
        ACT_CLR_ALL    = 5'd13,
        ACT_SET_REGION = 5'd14,
        ACT_SCROLL_UP  = 5'd15,
        ACT_SCROLL_DN  = 5'd16,
        ACT_INS_LINES  = 5'd17,
        ACT_DEL_LINES  = 5'd18,
        ACT_RESET      = 5'd19,
        ACT_CELL_EDIT  = 5'd20
    } action_t;

    localparam logic [2:0] SHIFT_NONE    = 3'd0;
    localparam logic [2:0] SHIFT_UP_HIST = 3'd1;
    localparam logic [2:0] SHIFT_UP_DISC = 3'd2;
    localparam logic [2:0] SHIFT_DOWN    = 3'd3;
    localparam logic [2:0] SHIFT_INSERT  = 3'd4;
    localparam logic [2:0] SHIFT_DELETE  = 3'd5;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_WRAP    = 2'd2;
    localparam logic [1:0] CFG_HISTORY = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic normalize;
        logic execute;
        logic tab_step;
        logic finish;
    } tcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tab;
        logic tab_done;
    } tcc_stat_t;

    function automatic logic default_stop(input int unsigned col);
        return (col >= TabSpacing) && (col % TabSpacing == 0);
    endfunction

endpackage

### src/terminal_cursor_controller.sv
// Top level of the terminal cursor controller.
`timescale 1ns / 1ps
// Takes one terminal command word per handshake and returns one result word with the new
// cursor, the cell a glyph write fills, any line to mark wrapped and the line shift the
// screen store must perform. An accepted command passes through the normalize and execute
// states and, for tab forward or back, a tab step state that walks the tab-stop bitmap
// column by column from the cursor column to the column where the cursor lands; a done
// state then loads the result word into the output register once that register is free.
// A new word is accepted only while the block is idle and the output register is empty
// or being emptied in the same cycle. Configuration writes go through cfg_we, cfg_index
// and cfg_data and must be made while the block is idle.
module terminal_cursor_controller import tcc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [4:0]        s_action,
    input  logic signed [9:0] s_first_arg,
    input  logic signed [9:0] s_second_arg,
    input  logic [1:0]        s_glyph_width,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [5:0]        m_cursor_row,
    output logic [7:0]        m_cursor_column,
    output logic              m_wrap_pending,
    output logic [1:0]        m_cell_write,
    output logic [5:0]        m_cell_row,
    output logic [7:0]        m_cell_column,
    output logic              m_wrap_mark,
    output logic [5:0]        m_wrap_row,
    output logic [2:0]        m_shift_kind,
    output logic [6:0]        m_shift_count,
    output logic [5:0]        m_shift_top,
    output logic [5:0]        m_shift_bottom
);

    tcc_cmd_t  cmd;
    tcc_stat_t stat;

    tcc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    tcc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .accept(s_valid && s_ready), .in_action(s_action),
        .in_first(s_first_arg), .in_second(s_second_arg), .in_width(s_glyph_width),
        .cmd(cmd), .stat(stat),
        .o_cursor_row(m_cursor_row), .o_cursor_column(m_cursor_column),
        .o_wrap_pending(m_wrap_pending), .o_cell_write(m_cell_write),
        .o_cell_row(m_cell_row), .o_cell_column(m_cell_column),
        .o_wrap_mark(m_wrap_mark), .o_wrap_row(m_wrap_row),
        .o_shift_kind(m_shift_kind), .o_shift_count(m_shift_count),
        .o_shift_top(m_shift_top), .o_shift_bottom(m_shift_bottom)
    );

endmodule

### src/tcc_ctrl.sv
// Controller state machine for the terminal cursor controller.
`timescale 1ns / 1ps
module tcc_ctrl import tcc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  tcc_stat_t stat,
    output tcc_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_NORM = 5'b00010,
        ST_EXEC = 5'b00100,
        ST_TAB  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // A new word enters while idle, once the output register is free or being emptied.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) state_next = ST_NORM;
            end
            ST_NORM: begin
                cmd.normalize = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = stat.is_tab ? ST_TAB : ST_DONE;
            end
            ST_TAB: begin
                cmd.tab_step = 1'b1;
                if (stat.tab_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid) else $error("finish without output");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_NORM) else $error("bad accept");
`endif

endmodule

### src/tcc_datapath.sv
// Cursor, region and tab-stop datapath of the terminal cursor controller.
`timescale 1ns / 1ps
module tcc_datapath import tcc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              accept,
    input  logic [4:0]        in_action,
    input  logic signed [9:0] in_first,
    input  logic signed [9:0] in_second,
    input  logic [1:0]        in_width,
    input  tcc_cmd_t          cmd,
    output tcc_stat_t         stat,
    output logic [5:0]        o_cursor_row,
    output logic [7:0]        o_cursor_column,
    output logic              o_wrap_pending,
    output logic [1:0]        o_cell_write,
    output logic [5:0]        o_cell_row,
    output logic [7:0]        o_cell_column,
    output logic              o_wrap_mark,
    output logic [5:0]        o_wrap_row,
    output logic [2:0]        o_shift_kind,
    output logic [6:0]        o_shift_count,
    output logic [5:0]        o_shift_top,
    output logic [5:0]        o_shift_bottom
);

    // Configuration.
    logic [8:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic        auto_wrap_reg;
    logic [15:0] history_reg;

    // Latched command.
    logic [4:0]        act_reg;
    logic signed [9:0] a1_reg, a2_reg;
    logic [1:0]        gw_reg;

    // Architectural state.
    logic [RowW-1:0]       row_reg, row_next;
    logic [ColW-1:0]       col_reg, col_next;
    logic                  wp_reg, wp_next;
    logic [RowW-1:0]       top_reg, top_next, bot_reg, bot_next;
    logic [MaxColumns-1:0] stops_reg, stops_next;

    // Per-command result fields.
    logic [1:0]      cw_reg, cw_next;
    logic [RowW-1:0] cr_reg, cr_next;
    logic [ColW-1:0] cc_reg, cc_next;
    logic            mk_reg, mk_next;
    logic [RowW-1:0] mr_reg, mr_next;
    logic [2:0]      sk_reg, sk_next;
    logic [RowW:0]   sc_reg, sc_next;
    logic [RowW-1:0] st_reg, st_next, sb_reg, sb_next;

    // Tab search.
    logic            tdir_reg, tdir_next;
    logic [ColW-1:0] tpos_reg, tpos_next;

    logic [9:0] cols, rows;   // effective sizes
    logic [9:0] lastc, lastr;
    always_comb begin
        cols = (columns_reg < 9'd2) ? 10'd2 :
               (columns_reg > 9'(MaxColumns)) ? 10'(MaxColumns) : {1'b0, columns_reg};
        rows = (rows_reg < 7'd1) ? 10'd1 :
               (rows_reg > 7'(MaxRows)) ? 10'(MaxRows) : {3'b0, rows_reg};
        lastc = cols - 10'd1;
        lastr = rows - 10'd1;
    end

    function automatic logic [9:0] clamp(input logic signed [11:0] v,
                                         input logic [9:0] lo, input logic [9:0] hi);
        if (v < $signed({2'b0, lo})) return lo;
        if (v > $signed({2'b0, hi})) return hi;
        return v[9:0];
    endfunction

    logic [MaxColumns-1:0] def_stops;
    always_comb begin
        for (int i = 0; i < MaxColumns; i++) def_stops[i] = default_stop(i);
    end

    logic tab_hit;
    assign tab_hit = stops_reg[tpos_reg];
    assign stat = '{
        is_tab:   (act_reg == ACT_TAB_FWD) || (act_reg == ACT_TAB_BACK),
        tab_done: tdir_reg ?
                  ((tpos_reg == '0) || (tpos_reg != col_reg && tab_hit)) :
                  (({2'b0, tpos_reg} >= lastc) || (tpos_reg != col_reg && tab_hit))
    };

    // Next-state logic: normalize, execute the latched command, or step the tab search.
    always_comb begin
        logic [RowW-1:0] r;
        logic [ColW-1:0] c;
        logic            wp;
        logic [10:0]     nc;
        logic [2:0]      w;
        logic            drop;
        logic [9:0]      span, tmp;
        logic [2:0]      upk;
        row_next = row_reg; col_next = col_reg; wp_next = wp_reg;
        top_next = top_reg; bot_next = bot_reg; stops_next = stops_reg;
        cw_next = cw_reg; cr_next = cr_reg; cc_next = cc_reg;
        mk_next = mk_reg; mr_next = mr_reg; sk_next = sk_reg;
        sc_next = sc_reg; st_next = st_reg; sb_next = sb_reg;
        tdir_next = tdir_reg; tpos_next = tpos_reg;
        r = row_reg; c = col_reg; wp = wp_reg; drop = 1'b0; nc = '0;
        w = (gw_reg[1]) ? 3'd2 : 3'd1;
        span = {4'b0, bot_reg} - {4'b0, top_reg} + 10'd1;
        upk = (top_reg == '0 && {4'b0, bot_reg} == lastr && history_reg != '0) ?
              SHIFT_UP_HIST : SHIFT_UP_DISC;
        tmp = '0;
        if (cmd.normalize) begin
            if ({4'b0, row_reg} > lastr) row_next = lastr[RowW-1:0];
            if ({2'b0, col_reg} > lastc) col_next = lastc[ColW-1:0];
            if ({4'b0, bot_reg} > lastr || top_reg > bot_reg) begin
                top_next = '0; bot_next = lastr[RowW-1:0];
            end
            cw_next = '0; cr_next = '0; cc_next = '0; mk_next = 1'b0; mr_next = '0;
            sk_next = SHIFT_NONE; sc_next = '0; st_next = '0; sb_next = '0;
        end else if (cmd.execute) begin
            unique case (act_reg)
                ACT_WRITE: begin
                    if (wp && auto_wrap_reg) begin
                        mk_next = 1'b1; mr_next = r; c = '0;
                        if (r == bot_reg) begin
                            sk_next = upk; sc_next = 7'd1; st_next = top_reg; sb_next = bot_reg;
                        end else if ({4'b0, r} < lastr) r = r + 1'b1;
                    end
                    if (w == 3'd2 && {2'b0, c} == lastc) begin
                        if (auto_wrap_reg) begin
                            mk_next = 1'b1; mr_next = r; c = '0;
                            if (r == bot_reg) begin
                                sk_next = upk; sc_next = 7'd1;
                                st_next = top_reg; sb_next = bot_reg;
                            end else if ({4'b0, r} < lastr) r = r + 1'b1;
                        end else drop = 1'b1;
                    end
                    if (!drop) begin
                        cw_next = w[1:0]; cr_next = r; cc_next = c;
                        nc = {3'b0, c} + {8'b0, w};
                        if (nc >= {1'b0, cols}) begin
                            c = lastc[ColW-1:0]; wp = 1'b1;
                        end else begin
                            c = nc[ColW-1:0]; wp = 1'b0;
                        end
                    end
                    row_next = r; col_next = c; wp_next = wp;
                end
                ACT_MOVE_ABS: begin
                    row_next = RowW'(clamp({{2{a1_reg[9]}}, a1_reg}, '0, lastr));
                    col_next = ColW'(clamp({{2{a2_reg[9]}}, a2_reg}, '0, lastc));
                    wp_next = 1'b0;
                end
                ACT_MOVE_REL: begin
                    row_next = RowW'(clamp({{2{a1_reg[9]}}, a1_reg} + 12'(row_reg), '0,
                                           lastr));
                    col_next = ColW'(clamp({{2{a2_reg[9]}}, a2_reg} + 12'(col_reg), '0,
                                           lastc));
                    wp_next = 1'b0;
                end
                ACT_SET_COL: begin
                    col_next = ColW'(clamp({{2{a2_reg[9]}}, a2_reg}, '0, lastc));
                    wp_next = 1'b0;
                end
                ACT_SET_ROW: begin
                    row_next = RowW'(clamp({{2{a1_reg[9]}}, a1_reg}, '0, lastr));
                    wp_next = 1'b0;
                end
                ACT_CR: begin
                    col_next = '0; wp_next = 1'b0;
                end
                ACT_INDEX, ACT_NEXT_LINE: begin
                    if (act_reg == ACT_NEXT_LINE) col_next = '0;
                    if (r == bot_reg) begin
                        sk_next = upk; sc_next = 7'd1; st_next = top_reg; sb_next = bot_reg;
                    end else if ({4'b0, r} < lastr) row_next = r + 1'b1;
                    wp_next = 1'b0;
                end
                ACT_REV_INDEX: begin
                    if (r == top_reg) begin
                        sk_next = SHIFT_DOWN; sc_next = 7'd1;
                        st_next = top_reg; sb_next = bot_reg;
                    end else if (r != '0) row_next = r - 1'b1;
                    wp_next = 1'b0;
                end
                ACT_TAB_FWD: begin
                    tdir_next = 1'b0; tpos_next = col_reg; wp_next = 1'b0;
                end
                ACT_TAB_BACK: begin
                    tdir_next = 1'b1; tpos_next = col_reg; wp_next = 1'b0;
                end
                ACT_SET_STOP, ACT_CLR_STOP: begin
                    if (!a1_reg[9] && {1'b0, a1_reg[8:0]} < cols)
                        stops_next[a1_reg[ColW-1:0]] = (act_reg == ACT_SET_STOP);
                end
                ACT_CLR_ALL: stops_next = '0;
                ACT_SET_REGION: begin
                    if (clamp({{2{a1_reg[9]}}, a1_reg}, '0, lastr) >=
                        clamp({{2{a2_reg[9]}}, a2_reg}, '0, lastr)) begin
                        top_next = '0; bot_next = lastr[RowW-1:0];
                    end else begin
                        top_next = RowW'(clamp({{2{a1_reg[9]}}, a1_reg}, '0, lastr));
                        bot_next = RowW'(clamp({{2{a2_reg[9]}}, a2_reg}, '0, lastr));
                    end
                end
                ACT_SCROLL_UP, ACT_SCROLL_DN: begin
                    sk_next = (act_reg == ACT_SCROLL_UP) ? upk : SHIFT_DOWN;
                    sc_next = (RowW+1)'(clamp({{2{a1_reg[9]}}, a1_reg}, 10'd1, span));
                    st_next = top_reg; sb_next = bot_reg;
                end
                ACT_INS_LINES, ACT_DEL_LINES: begin
                    if (r >= top_reg && r <= bot_reg) begin
                        tmp = {4'b0, bot_reg} - {4'b0, r} + 10'd1;
                        sk_next = (act_reg == ACT_INS_LINES) ? SHIFT_INSERT : SHIFT_DELETE;
                        sc_next = (RowW+1)'(clamp({{2{a1_reg[9]}}, a1_reg}, 10'd1, tmp));
                        st_next = r; sb_next = bot_reg;
                        col_next = '0; wp_next = 1'b0;
                    end
                end
                ACT_RESET: begin
                    row_next = '0; col_next = '0; wp_next = 1'b0;
                    top_next = '0; bot_next = lastr[RowW-1:0]; stops_next = def_stops;
                end
                ACT_CELL_EDIT: wp_next = 1'b0;
                default: ;
            endcase
        end else if (cmd.tab_step) begin
            // One column a cycle, starting at the cursor itself, which never counts as a stop.
            if (stat.tab_done) begin
                if (tdir_reg) col_next = (tpos_reg != col_reg && tab_hit) ? tpos_reg : '0;
                else col_next = (tpos_reg != col_reg && tab_hit) ? tpos_reg
                                                                 : lastc[ColW-1:0];
            end else begin
                tpos_next = tdir_reg ? tpos_reg - 1'b1 : tpos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= 9'd80; rows_reg <= 7'd24;
            auto_wrap_reg <= 1'b1; history_reg <= 16'd1000;
            row_reg <= '0; col_reg <= '0; wp_reg <= 1'b0;
            top_reg <= '0; bot_reg <= 6'd23; stops_reg <= def_stops;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COLUMNS: columns_reg   <= cfg_data[8:0];
                    CFG_ROWS:    rows_reg      <= cfg_data[6:0];
                    CFG_WRAP:    auto_wrap_reg <= cfg_data[0];
                    CFG_HISTORY: history_reg   <= cfg_data;
                    default: ;
                endcase
            end
            row_reg <= row_next; col_reg <= col_next; wp_reg <= wp_next;
            top_reg <= top_next; bot_reg <= bot_next; stops_reg <= stops_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= in_action; a1_reg <= in_first;
            a2_reg <= in_second;  gw_reg <= in_width;
        end
        cw_reg <= cw_next; cr_reg <= cr_next; cc_reg <= cc_next;
        mk_reg <= mk_next; mr_reg <= mr_next; sk_reg <= sk_next;
        sc_reg <= sc_next; st_reg <= st_next; sb_reg <= sb_next;
        tdir_reg <= tdir_next; tpos_reg <= tpos_next;
        if (cmd.finish) begin
            o_cursor_row <= row_reg; o_cursor_column <= col_reg;
            o_wrap_pending <= wp_reg; o_cell_write <= cw_reg;
            o_cell_row <= cr_reg; o_cell_column <= cc_reg;
            o_wrap_mark <= mk_reg; o_wrap_row <= mr_reg;
            o_shift_kind <= sk_reg; o_shift_count <= sc_reg;
            o_shift_top <= st_reg; o_shift_bottom <= sb_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_region: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> top_reg <= bot_reg) else $error("region inverted");
    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> {2'b0, col_reg} <= lastc) else $error("column off screen");
    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && sk_reg == SHIFT_NONE |-> sc_reg == '0) else $error("stray count");
`endif

endmodule

### tb/tcc_checker.sv
// Checker for the terminal cursor controller: predicts each result word and compares it.
`timescale 1ns / 1ps
module tcc_checker import tcc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [4:0]        s_action,
    input  logic signed [9:0] s_first_arg,
    input  logic signed [9:0] s_second_arg,
    input  logic [1:0]        s_glyph_width,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [5:0]        m_cursor_row,
    input  logic [7:0]        m_cursor_column,
    input  logic              m_wrap_pending,
    input  logic [1:0]        m_cell_write,
    input  logic [5:0]        m_cell_row,
    input  logic [7:0]        m_cell_column,
    input  logic              m_wrap_mark,
    input  logic [5:0]        m_wrap_row,
    input  logic [2:0]        m_shift_kind,
    input  logic [6:0]        m_shift_count,
    input  logic [5:0]        m_shift_top,
    input  logic [5:0]        m_shift_bottom,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic [5:0] cursor_row;
        logic [7:0] cursor_column;
        logic       wrap_pending;
        logic [1:0] cell_write;
        logic [5:0] cell_row;
        logic [7:0] cell_column;
        logic       wrap_mark;
        logic [5:0] wrap_row;
        logic [2:0] shift_kind;
        logic [6:0] shift_count;
        logic [5:0] shift_top;
        logic [5:0] shift_bottom;
    } cursor_result_t;

    localparam int ExpDepth = 16;

    cursor_result_t expected_mem[ExpDepth];
    int             exp_wr, exp_rd;

    logic [8:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic        wrap_reg;
    logic [15:0] history_reg;
    int          row_q, col_q, region_top_q, region_bot_q;
    logic        wrap_q;
    logic        stops[MaxColumns];
    int          sk, sc, st, sb;

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int screen_cols();
        return clamp(int'(columns_reg), 2, MaxColumns);
    endfunction

    function automatic int screen_rows();
        return clamp(int'(rows_reg), 1, MaxRows);
    endfunction

    task automatic reset_stops();
        for (int i = 0; i < MaxColumns; i++) stops[i] = (i >= TabSpacing) && (i % TabSpacing == 0);
    endtask

    task automatic region_scroll(int n);
        sc = clamp(n, 1, region_bot_q - region_top_q + 1);
        sk = (region_top_q == 0 && region_bot_q == screen_rows() - 1 && history_reg != 0)
             ? SHIFT_UP_HIST : SHIFT_UP_DISC;
        st = region_top_q;
        sb = region_bot_q;
    endtask

    task automatic line_feed();
        if (row_q == region_bot_q) region_scroll(1);
        else if (row_q < screen_rows() - 1) row_q++;
        wrap_q = 1'b0;
    endtask

    task automatic line_edit(int kind, int n);
        if (row_q < region_top_q || row_q > region_bot_q) return;
        sk = kind;
        sc = clamp(n, 1, region_bot_q - row_q + 1);
        st = row_q;
        sb = region_bot_q;
        col_q = 0;
        wrap_q = 1'b0;
    endtask

    task automatic predict_command(logic [4:0] act, int a1, int a2, logic [1:0] gw);
        int cols, rows, w, cell_k, cell_r, cell_c, mark, mark_row, dest;
        bit drop;
        cursor_result_t r;
        cols = screen_cols();
        rows = screen_rows();
        cell_k = 0; cell_r = 0; cell_c = 0; mark = 0; mark_row = 0;
        sk = 0; sc = 0; st = 0; sb = 0;
        if (row_q > rows - 1) row_q = rows - 1;
        if (col_q > cols - 1) col_q = cols - 1;
        if (region_bot_q > rows - 1 || region_top_q > region_bot_q) begin
            region_top_q = 0;
            region_bot_q = rows - 1;
        end
        case (act)
            ACT_WRITE: begin
                w = (gw <= 2'd1) ? 1 : 2;
                drop = 0;
                if (wrap_q && wrap_reg) begin
                    mark = 1; mark_row = row_q; col_q = 0;
                    line_feed();
                end
                if (w == 2 && col_q == cols - 1) begin
                    if (wrap_reg) begin
                        mark = 1; mark_row = row_q; col_q = 0;
                        line_feed();
                    end else begin
                        drop = 1;
                    end
                end
                if (!drop) begin
                    cell_k = w; cell_r = row_q; cell_c = col_q;
                    col_q += w;
                    if (col_q >= cols) begin
                        col_q = cols - 1;
                        wrap_q = 1'b1;
                    end else begin
                        wrap_q = 1'b0;
                    end
                end
            end
            ACT_MOVE_ABS: begin
                row_q = clamp(a1, 0, rows - 1); col_q = clamp(a2, 0, cols - 1); wrap_q = 0;
            end
            ACT_MOVE_REL: begin
                row_q = clamp(row_q + a1, 0, rows - 1);
                col_q = clamp(col_q + a2, 0, cols - 1);
                wrap_q = 0;
            end
            ACT_SET_COL: begin col_q = clamp(a2, 0, cols - 1); wrap_q = 0; end
            ACT_SET_ROW: begin row_q = clamp(a1, 0, rows - 1); wrap_q = 0; end
            ACT_CR: begin col_q = 0; wrap_q = 0; end
            ACT_INDEX: line_feed();
            ACT_REV_INDEX: begin
                if (row_q == region_top_q) begin
                    sk = SHIFT_DOWN; sc = 1; st = region_top_q; sb = region_bot_q;
                end else if (row_q > 0) begin
                    row_q--;
                end
                wrap_q = 0;
            end
            ACT_NEXT_LINE: begin col_q = 0; line_feed(); end
            ACT_TAB_FWD: begin
                dest = cols - 1;
                for (int i = col_q + 1; i < cols; i++) if (stops[i]) begin dest = i; break; end
                col_q = dest; wrap_q = 0;
            end
            ACT_TAB_BACK: begin
                dest = 0;
                for (int i = col_q - 1; i > 0; i--) if (stops[i]) begin dest = i; break; end
                col_q = dest; wrap_q = 0;
            end
            ACT_SET_STOP: if (a1 >= 0 && a1 < cols) stops[a1] = 1'b1;
            ACT_CLR_STOP: if (a1 >= 0 && a1 < cols) stops[a1] = 1'b0;
            ACT_CLR_ALL: for (int i = 0; i < MaxColumns; i++) stops[i] = 1'b0;
            ACT_SET_REGION: begin
                w = clamp(a1, 0, rows - 1);
                dest = clamp(a2, 0, rows - 1);
                if (w >= dest) begin
                    region_top_q = 0; region_bot_q = rows - 1;
                end else begin
                    region_top_q = w; region_bot_q = dest;
                end
            end
            ACT_SCROLL_UP: region_scroll(a1);
            ACT_SCROLL_DN: begin
                sk = SHIFT_DOWN; sc = clamp(a1, 1, region_bot_q - region_top_q + 1);
                st = region_top_q; sb = region_bot_q;
            end
            ACT_INS_LINES: line_edit(SHIFT_INSERT, a1);
            ACT_DEL_LINES: line_edit(SHIFT_DELETE, a1);
            ACT_RESET: begin
                row_q = 0; col_q = 0; wrap_q = 0;
                region_top_q = 0; region_bot_q = rows - 1;
                reset_stops();
            end
            ACT_CELL_EDIT: wrap_q = 0;
            default: ;
        endcase
        r.cursor_row = row_q[5:0];
        r.cursor_column = col_q[7:0];
        r.wrap_pending = wrap_q;
        r.cell_write = cell_k[1:0];
        r.cell_row = cell_r[5:0];
        r.cell_column = cell_c[7:0];
        r.wrap_mark = mark[0];
        r.wrap_row = mark_row[5:0];
        r.shift_kind = sk[2:0];
        r.shift_count = sc[6:0];
        r.shift_top = st[5:0];
        r.shift_bottom = sb[5:0];
        expected_mem[exp_wr % ExpDepth] = r;
        exp_wr++;
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        cursor_result_t e;
        if (!aresetn) begin
            columns_reg <= 9'd80; rows_reg <= 7'd24; wrap_reg <= 1'b1; history_reg <= 16'd1000;
            row_q = 0; col_q = 0; wrap_q = 0; region_top_q = 0; region_bot_q = 23;
            reset_stops();
            exp_wr = 0;
            exp_rd = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COLUMNS: columns_reg <= cfg_data[8:0];
                    CFG_ROWS:    rows_reg <= cfg_data[6:0];
                    CFG_WRAP:    wrap_reg <= cfg_data[0];
                    default:     history_reg <= cfg_data;
                endcase
            end
            if (s_valid && s_ready)
                predict_command(s_action, int'(s_first_arg), int'(s_second_arg), s_glyph_width);
            if (m_valid && m_ready) begin
                if (exp_wr == exp_rd) begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end else begin
                    e = expected_mem[exp_rd % ExpDepth];
                    exp_rd++;
                    check_field("cursor_row", e.cursor_row, m_cursor_row);
                    check_field("cursor_column", e.cursor_column, m_cursor_column);
                    check_field("wrap_pending", e.wrap_pending, m_wrap_pending);
                    check_field("cell_write", e.cell_write, m_cell_write);
                    check_field("cell_row", e.cell_row, m_cell_row);
                    check_field("cell_column", e.cell_column, m_cell_column);
                    check_field("wrap_mark", e.wrap_mark, m_wrap_mark);
                    check_field("wrap_row", e.wrap_row, m_wrap_row);
                    check_field("shift_kind", e.shift_kind, m_shift_kind);
                    check_field("shift_count", e.shift_count, m_shift_count);
                    check_field("shift_top", e.shift_top, m_shift_top);
                    check_field("shift_bottom", e.shift_bottom, m_shift_bottom);
                end
            end
        end
        pending_count = exp_wr - exp_rd;
    end

endmodule

### tb/tb_terminal_cursor_controller.sv
// Testbench top for the terminal cursor controller: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_terminal_cursor_controller;
    import tcc_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [4:0]        s_action = '0;
    logic signed [9:0] s_first_arg = '0;
    logic signed [9:0] s_second_arg = '0;
    logic [1:0]        s_glyph_width = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [5:0]        m_cursor_row;
    logic [7:0]        m_cursor_column;
    logic              m_wrap_pending;
    logic [1:0]        m_cell_write;
    logic [5:0]        m_cell_row;
    logic [7:0]        m_cell_column;
    logic              m_wrap_mark;
    logic [5:0]        m_wrap_row;
    logic [2:0]        m_shift_kind;
    logic [6:0]        m_shift_count;
    logic [5:0]        m_shift_top;
    logic [5:0]        m_shift_bottom;
    int                fail_count;
    int                pending_count;
    bit                long_hold;
    bit                hold_done;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    terminal_cursor_controller dut (.*);

    tcc_checker checker_i (.*);

    // Drives one command word and holds it until the block takes it. Valid stays up
    // after acceptance only when the next word follows in the same cycle.
    task automatic send_command(action_t act, int a1, int a2, int gw);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_first_arg   <= a1[9:0];
        s_second_arg  <= a2[9:0];
        s_glyph_width <= gw[1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drops valid and waits for every expected word, then lets the block settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Random argument: mostly near the screen, sometimes anywhere in range.
    function automatic int rand_arg();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1023) - 512;
            1:       return $urandom_range(0, 8) - 4;
            default: return $urandom_range(0, 70);
        endcase
    endfunction

    // A random command. Writes dominate so the cursor reaches the edge and wraps.
    task automatic send_random();
        int pick;
        action_t act;
        pick = $urandom_range(0, 99);
        if (pick < 45) act = ACT_WRITE;
        else act = action_t'($urandom_range(1, 20));
        if ($urandom_range(0, 60) == 0) act = action_t'($urandom_range(21, 31));
        send_command(act, rand_arg(), rand_arg(), $urandom_range(0, 3));
    endtask

    // Receiver: random stalls per word, one long hold-off while the sender keeps going.
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (long_hold && !hold_done) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                hold_done = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int col_set[5];
        int row_set[5];
        col_set = '{2, 256, 80, 511, 17};
        row_set = '{1, 64, 24, 127, 5};
        long_hold = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: field extremes and each special case.
        send_command(ACT_MOVE_ABS, 511, 511, 0);
        send_command(ACT_WRITE, 0, 0, 2);
        send_command(ACT_WRITE, 0, 0, 1);
        send_command(ACT_WRITE, -512, -512, 3);
        send_command(ACT_MOVE_REL, -512, -512, 0);
        send_command(ACT_SET_COL, 0, 79, 0);
        send_command(ACT_SET_ROW, 23, 0, 0);
        send_command(ACT_WRITE, 0, 0, 1);
        send_command(ACT_WRITE, 0, 0, 0);
        send_command(ACT_CR, 0, 0, 0);
        send_command(ACT_TAB_FWD, 0, 0, 0);
        send_command(ACT_TAB_BACK, 0, 0, 0);
        send_command(ACT_SET_STOP, 3, 0, 0);
        send_command(ACT_CLR_STOP, 8, 0, 0);
        send_command(ACT_SET_STOP, 300, 0, 0);
        send_command(ACT_SET_REGION, 5, 10, 0);
        send_command(ACT_INS_LINES, 511, 0, 0);
        send_command(ACT_SET_ROW, 8, 0, 0);
        send_command(ACT_DEL_LINES, -3, 0, 0);
        send_command(ACT_INDEX, 0, 0, 0);
        send_command(ACT_REV_INDEX, 0, 0, 0);
        send_command(ACT_SCROLL_UP, 100, 0, 0);
        send_command(ACT_SCROLL_DN, 0, 0, 0);
        send_command(ACT_CLR_ALL, 0, 0, 0);
        send_command(ACT_TAB_FWD, 0, 0, 0);
        send_command(ACT_NEXT_LINE, 0, 0, 0);
        send_command(ACT_CELL_EDIT, 0, 0, 0);
        send_command(ACT_RESET, 0, 0, 0);

        // Long receiver hold-off while commands keep coming.
        long_hold = 1'b1;
        repeat (40) send_random();

        // Random phases, each with its own register settings.
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            write_reg(CFG_COLUMNS, (phase < 5) ? col_set[phase] : $urandom_range(0, 511));
            write_reg(CFG_ROWS, (phase < 5) ? row_set[phase] : $urandom_range(0, 127));
            write_reg(CFG_WRAP, phase % 2);
            write_reg(CFG_HISTORY, (phase % 3 == 0) ? 0 : ((phase == 1) ? 65535 : $urandom));
            repeat (130) send_random();
        end

        wait_idle();
        if (fail_count == 0)
            $display("terminal_cursor_controller test passed");
        else
            $display("terminal_cursor_controller test failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("terminal_cursor_controller test failed");
        $finish;
    end

endmodule
